// ===== hdl/expert_slot_cache_controller_assert.svh =====
// Assertion macros shared by the slot cache controller modules.
`ifndef EXPERT_SLOT_CACHE_CONTROLLER_ASSERT_SVH
`define EXPERT_SLOT_CACHE_CONTROLLER_ASSERT_SVH
`ifndef SYNTH
`define ESC_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define ESC_ASSERT_NXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define ESC_ASSERT_IMP(label, clk, rst, a, c, msg)
`define ESC_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

// ===== hdl/esc_pkg.sv =====
// Shared types, codes and constants of the expert slot cache controller.
package esc_pkg;
   localparam int SLOTS = 64;
   localparam int SW = $clog2(SLOTS);
   localparam int CW = 48;

   localparam logic [2:0] OP_PREFETCH = 3'd0;
   localparam logic [2:0] OP_DEMAND   = 3'd1;
   localparam logic [2:0] OP_USE      = 3'd2;
   localparam logic [2:0] OP_UNPIN    = 3'd3;
   localparam logic [2:0] OP_RELEASE  = 3'd4;
   localparam logic [2:0] OP_POP      = 3'd5;
   localparam logic [2:0] OP_COMPLETE = 3'd6;

   localparam logic [3:0] RS_HIT      = 4'd0;
   localparam logic [3:0] RS_PROMOTED = 4'd1;
   localparam logic [3:0] RS_LOADING  = 4'd2;
   localparam logic [3:0] RS_ENQUEUED = 4'd3;
   localparam logic [3:0] RS_NO_SLOT  = 4'd4;
   localparam logic [3:0] RS_JOB      = 4'd5;
   localparam logic [3:0] RS_NO_JOB   = 4'd6;
   localparam logic [3:0] RS_DONE     = 4'd7;
   localparam logic [3:0] RS_NOT_RDY  = 4'd8;

   localparam logic [1:0] ST_QUEUED  = 2'd0;
   localparam logic [1:0] ST_LOADING = 2'd1;
   localparam logic [1:0] ST_READY   = 2'd2;
   localparam logic [1:0] ST_FAILED  = 2'd3;

   localparam logic [1:0] CSR_POLICY = 2'd0;
   localparam logic [1:0] CSR_SLOTS  = 2'd1;
   localparam logic [1:0] CSR_STRIDE = 2'd2;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_APPLY,
      FSM_MUL,
      FSM_OUT
   } fsm_state_type;

   typedef struct packed {
      logic       start;
      logic       scan;
      logic       apply;
      logic       mul;
      logic       load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_busy;
   } ctrl_stat_type;
endpackage

// ===== hdl/esc_if.sv =====
// Valid/ready channel interfaces of the controller.
interface esc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [7:0] layer;
   logic [9:0] expert;
   logic [5:0] done_slot;
   logic       load_ok;
   modport source (output valid, op, layer, expert, done_slot, load_ok, input ready);
   modport sink (input valid, op, layer, expert, done_slot, load_ok, output ready);
endinterface

interface esc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [5:0]  slot;
   logic [55:0] byte_offset;
   logic [7:0]  job_layer;
   logic [9:0]  job_expert;
   logic        evicted;
   modport source (output valid, status, slot, byte_offset, job_layer, job_expert, evicted,
                   input ready);
   modport sink (input valid, status, slot, byte_offset, job_layer, job_expert, evicted,
                 output ready);
endinterface

interface esc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [39:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/esc_ctrl.sv =====
// Sequencing state machine: accept, scan the slots, apply, scale, respond.
module esc_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_fire,
   input  esc_pkg::ctrl_stat_type       stat,
   output esc_pkg::ctrl_cmd_type        cmd,
   output logic                         req_ready
);
   esc_pkg::fsm_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         esc_pkg::FSM_IDLE:  if (req_fire) state_in = esc_pkg::FSM_SCAN;
         esc_pkg::FSM_SCAN:  if (stat.scan_last) state_in = esc_pkg::FSM_APPLY;
         esc_pkg::FSM_APPLY: state_in = esc_pkg::FSM_MUL;
         esc_pkg::FSM_MUL:   state_in = esc_pkg::FSM_OUT;
         esc_pkg::FSM_OUT:   if (!stat.out_busy) state_in = esc_pkg::FSM_IDLE;
         default:            state_in = esc_pkg::FSM_IDLE;
      endcase
   end

   // Commands.
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         esc_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_fire;
         end
         esc_pkg::FSM_SCAN:  cmd.scan = 1'b1;
         esc_pkg::FSM_APPLY: cmd.apply = 1'b1;
         esc_pkg::FSM_MUL:   cmd.mul = 1'b1;
         esc_pkg::FSM_OUT:   cmd.load_out = !stat.out_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= esc_pkg::FSM_IDLE;
      else state_ff <= state_in;
   end

`include "expert_slot_cache_controller_assert.svh"
   `ESC_ASSERT_NXT(a_start_scan, clock, reset, req_fire, state_ff == esc_pkg::FSM_SCAN, "no scan")
   `ESC_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == esc_pkg::FSM_IDLE, "ready")
   `ESC_ASSERT_NXT(a_apply_mul, clock, reset, cmd.apply, cmd.mul, "apply not followed by mul")
endmodule

// ===== hdl/esc_dp.sv =====
// Slot table, job queue, sequential slot scan and response register.
module esc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  esc_pkg::ctrl_cmd_type  cmd,
   output esc_pkg::ctrl_stat_type stat,
   input  logic [2:0]             i_op,
   input  logic [7:0]             i_layer,
   input  logic [9:0]             i_expert,
   input  logic [5:0]             i_done_slot,
   input  logic                   i_load_ok,
   input  logic                   csr_we,
   input  logic [1:0]             csr_idx,
   input  logic [39:0]            csr_wdata,
   output logic                   o_valid,
   input  logic                   o_ready,
   output logic [3:0]             o_status,
   output logic [5:0]             o_slot,
   output logic [55:0]            o_offset,
   output logic [7:0]             o_job_layer,
   output logic [9:0]             o_job_expert,
   output logic                   o_evicted
);
   // Configuration.
   logic        policy_ff;
   logic [6:0]  nslots_ff;
   logic [39:0] stride_ff;

   // Slot flags in flip-flops.
   logic [esc_pkg::SLOTS-1:0] valid_ff, pinned_ff, pending_ff;

   // Slot payload memories, read one slot per cycle through registered read data.
   logic [7:0]             lay_mem [esc_pkg::SLOTS];
   logic [9:0]             exp_mem [esc_pkg::SLOTS];
   logic [1:0]             st_mem  [esc_pkg::SLOTS];
   logic [esc_pkg::CW-1:0] lu_mem  [esc_pkg::SLOTS];
   logic                   urg_mem [esc_pkg::SLOTS];
   logic [esc_pkg::CW-1:0] seq_mem [esc_pkg::SLOTS];
   logic [esc_pkg::CW-1:0] srt_mem [esc_pkg::SLOTS];
   logic [esc_pkg::CW-1:0] use_ff, ord_ff;

   // Read data of the slot under examination.
   logic [7:0]             rd_lay_ff;
   logic [9:0]             rd_exp_ff;
   logic [1:0]             rd_st_ff;
   logic [esc_pkg::CW-1:0] rd_lu_ff;
   logic                   rd_urg_ff;
   logic [esc_pkg::CW-1:0] rd_seq_ff, rd_srt_ff;

   // Latched request.
   logic [2:0] op_ff;
   logic [7:0] lay_ff;
   logic [9:0] exp_ff;
   logic [5:0] dslot_ff;
   logic       ok_ff;

   // Scan state and search results.
   logic [esc_pkg::SW:0]   idx_ff;
   logic [esc_pkg::SW:0]   limit;
   logic                   ev_vld_ff;
   logic [esc_pkg::SW-1:0] ev_idx_ff;
   logic                   key_hit_ff, free_hit_ff, vic_hit_ff, job_hit_ff;
   logic [esc_pkg::SW-1:0] key_ff, free_ff, vic_ff, job_ff;
   logic [1:0]             key_st_ff, dst_ff;
   logic [esc_pkg::CW-1:0] vic_lu_ff;
   logic                   job_urg_ff;
   logic [7:0]             job_lay_ff;
   logic [9:0]             job_exp_ff;
   logic [esc_pkg::CW-1:0] job_srt_ff, job_seq_ff;

   // Result under construction.
   logic [3:0]             res_status_ff, res_status_in;
   logic                   res_has_ff, res_has_in;
   logic [esc_pkg::SW-1:0] res_slot_ff, res_slot_in;
   logic [7:0]             res_jl_ff, res_jl_in;
   logic [9:0]             res_je_ff, res_je_in;
   logic                   res_ev_ff, res_ev_in;
   logic [55:0]            prod_ff;

   assign limit = (nslots_ff > 7'(esc_pkg::SLOTS)) ? (esc_pkg::SW+1)'(esc_pkg::SLOTS)
                                                   : (esc_pkg::SW+1)'(nslots_ff);

   logic [esc_pkg::SW-1:0] cur;
   assign cur = idx_ff[esc_pkg::SW-1:0];
   // The last scan cycle checks the slot read on the cycle before.
   assign stat = '{scan_last: (idx_ff >= limit), out_busy: (o_valid && !o_ready)};

   // Candidate comparison for the slot whose data has been read.
   logic cand_job_better;
   always_comb begin
      cand_job_better = 1'b0;
      if (!job_hit_ff) cand_job_better = 1'b1;
      else if (rd_urg_ff != job_urg_ff) cand_job_better = rd_urg_ff;
      else if (policy_ff && rd_lay_ff != job_lay_ff) cand_job_better = rd_lay_ff < job_lay_ff;
      else if (policy_ff && rd_srt_ff != job_srt_ff) cand_job_better = rd_srt_ff < job_srt_ff;
      else cand_job_better = rd_seq_ff < job_seq_ff;
   end

   // Apply-step decisions.
   logic                   is_req, do_enq, take_ok, cpl_ok;
   logic [esc_pkg::SW-1:0] tgt;
   logic                   tgt_ev;
   assign is_req = (op_ff <= esc_pkg::OP_USE);
   assign cpl_ok = ((esc_pkg::SW+1)'(dslot_ff) < limit) && valid_ff[dslot_ff[esc_pkg::SW-1:0]]
                   && (dst_ff == esc_pkg::ST_LOADING);
   always_comb begin
      do_enq = is_req && !(key_hit_ff &&
               (key_st_ff == esc_pkg::ST_READY || key_st_ff == esc_pkg::ST_QUEUED ||
                key_st_ff == esc_pkg::ST_LOADING));
      tgt = key_ff;
      tgt_ev = 1'b0;
      take_ok = 1'b1;
      if (!key_hit_ff) begin
         if (free_hit_ff) tgt = free_ff;
         else if (vic_hit_ff) begin
            tgt = vic_ff;
            tgt_ev = 1'b1;
         end else take_ok = 1'b0;
      end
   end

   // Response fields of the operation.
   always_comb begin
      res_status_in = esc_pkg::RS_NOT_RDY;
      res_has_in = 1'b0;
      res_slot_in = '0;
      res_jl_in = '0;
      res_je_in = '0;
      res_ev_in = 1'b0;
      if (is_req) begin
         if (!do_enq) begin
            res_has_in = 1'b1;
            res_slot_in = key_ff;
            if (key_st_ff == esc_pkg::ST_READY) res_status_in = esc_pkg::RS_HIT;
            else if (key_st_ff == esc_pkg::ST_QUEUED && op_ff != esc_pkg::OP_PREFETCH)
               res_status_in = esc_pkg::RS_PROMOTED;
            else res_status_in = esc_pkg::RS_LOADING;
         end else if (!take_ok) begin
            res_status_in = esc_pkg::RS_NO_SLOT;
         end else begin
            res_status_in = esc_pkg::RS_ENQUEUED;
            res_has_in = 1'b1;
            res_slot_in = tgt;
            res_ev_in = tgt_ev;
         end
      end else if (op_ff == esc_pkg::OP_UNPIN) begin
         if (key_hit_ff) begin
            res_status_in = esc_pkg::RS_DONE;
            res_has_in = 1'b1;
            res_slot_in = key_ff;
         end
      end else if (op_ff == esc_pkg::OP_RELEASE) begin
         res_status_in = esc_pkg::RS_DONE;
      end else if (op_ff == esc_pkg::OP_POP) begin
         if (!job_hit_ff) res_status_in = esc_pkg::RS_NO_JOB;
         else begin
            res_status_in = esc_pkg::RS_JOB;
            res_jl_in = job_lay_ff;
            res_je_in = job_exp_ff;
            res_has_in = 1'b1;
            res_slot_in = job_ff;
         end
      end else if (op_ff == esc_pkg::OP_COMPLETE) begin
         if (cpl_ok) begin
            res_status_in = esc_pkg::RS_DONE;
            res_has_in = 1'b1;
            res_slot_in = dslot_ff[esc_pkg::SW-1:0];
         end
      end
   end

   // Payload memories: one registered read per scan cycle, one write per apply step.
   always_ff @(posedge clock) begin
      if (cmd.scan && idx_ff < limit) begin
         rd_lay_ff <= lay_mem[cur];
         rd_exp_ff <= exp_mem[cur];
         rd_st_ff <= st_mem[cur];
         rd_lu_ff <= lu_mem[cur];
         rd_urg_ff <= urg_mem[cur];
         rd_seq_ff <= seq_mem[cur];
         rd_srt_ff <= srt_mem[cur];
      end
      if (cmd.apply) begin
         if (is_req && !do_enq) begin
            if (key_st_ff == esc_pkg::ST_READY) lu_mem[key_ff] <= use_ff + 1'b1;
            else if (key_st_ff == esc_pkg::ST_QUEUED && op_ff != esc_pkg::OP_PREFETCH) begin
               urg_mem[key_ff] <= 1'b1;
               srt_mem[key_ff] <= '0;
            end
         end else if (do_enq && take_ok) begin
            lay_mem[tgt] <= lay_ff;
            exp_mem[tgt] <= exp_ff;
            st_mem[tgt] <= esc_pkg::ST_QUEUED;
            lu_mem[tgt] <= use_ff + 1'b1;
            urg_mem[tgt] <= (op_ff != esc_pkg::OP_PREFETCH);
            seq_mem[tgt] <= ord_ff + 1'b1;
            srt_mem[tgt] <= ord_ff + 1'b1;
         end else if (op_ff == esc_pkg::OP_POP && job_hit_ff) begin
            st_mem[job_ff] <= esc_pkg::ST_LOADING;
         end else if (op_ff == esc_pkg::OP_COMPLETE && cpl_ok) begin
            st_mem[dslot_ff[esc_pkg::SW-1:0]] <= ok_ff ? esc_pkg::ST_READY : esc_pkg::ST_FAILED;
            lu_mem[dslot_ff[esc_pkg::SW-1:0]] <= use_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= 1'b0;
         nslots_ff <= 7'd64;
         stride_ff <= 40'd1;
         valid_ff <= '0;
         pinned_ff <= '0;
         pending_ff <= '0;
         use_ff <= '0;
         ord_ff <= '0;
         o_valid <= 1'b0;
         idx_ff <= '0;
         ev_vld_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_idx)
               esc_pkg::CSR_POLICY: policy_ff <= csr_wdata[0];
               esc_pkg::CSR_SLOTS:  nslots_ff <= csr_wdata[6:0];
               esc_pkg::CSR_STRIDE: stride_ff <= csr_wdata;
               default: ;
            endcase
         end

         // Capture the request and clear the search.
         if (cmd.start) begin
            op_ff <= i_op;
            lay_ff <= i_layer;
            exp_ff <= i_expert;
            dslot_ff <= i_done_slot;
            ok_ff <= i_load_ok;
            idx_ff <= '0;
            ev_vld_ff <= 1'b0;
            key_hit_ff <= 1'b0;
            free_hit_ff <= 1'b0;
            vic_hit_ff <= 1'b0;
            job_hit_ff <= 1'b0;
            dst_ff <= esc_pkg::ST_QUEUED;
         end

         // Read one slot per cycle and check the slot read on the cycle before.
         if (cmd.scan) begin
            ev_vld_ff <= (idx_ff < limit);
            ev_idx_ff <= cur;
            idx_ff <= idx_ff + 1'b1;
            if (ev_vld_ff) begin
               if (!key_hit_ff && valid_ff[ev_idx_ff] && rd_lay_ff == lay_ff
                   && rd_exp_ff == exp_ff) begin
                  key_hit_ff <= 1'b1;
                  key_ff <= ev_idx_ff;
                  key_st_ff <= rd_st_ff;
               end
               if (!free_hit_ff && !valid_ff[ev_idx_ff]) begin
                  free_hit_ff <= 1'b1;
                  free_ff <= ev_idx_ff;
               end
               if (valid_ff[ev_idx_ff] && !pinned_ff[ev_idx_ff]
                   && rd_st_ff != esc_pkg::ST_LOADING
                   && (!vic_hit_ff || rd_lu_ff < vic_lu_ff)) begin
                  vic_hit_ff <= 1'b1;
                  vic_ff <= ev_idx_ff;
                  vic_lu_ff <= rd_lu_ff;
               end
               if (op_ff == esc_pkg::OP_RELEASE && valid_ff[ev_idx_ff] && rd_lay_ff == lay_ff)
                  pinned_ff[ev_idx_ff] <= 1'b0;
               if (pending_ff[ev_idx_ff] && cand_job_better) begin
                  job_hit_ff <= 1'b1;
                  job_ff <= ev_idx_ff;
                  job_urg_ff <= rd_urg_ff;
                  job_lay_ff <= rd_lay_ff;
                  job_exp_ff <= rd_exp_ff;
                  job_srt_ff <= rd_srt_ff;
                  job_seq_ff <= rd_seq_ff;
               end
               if (ev_idx_ff == dslot_ff[esc_pkg::SW-1:0]) dst_ff <= rd_st_ff;
            end
         end

         // Apply the operation to the flags and counters.
         if (cmd.apply) begin
            res_status_ff <= res_status_in;
            res_has_ff <= res_has_in;
            res_slot_ff <= res_slot_in;
            res_jl_ff <= res_jl_in;
            res_je_ff <= res_je_in;
            res_ev_ff <= res_ev_in;
            if (is_req && !do_enq) begin
               if (key_st_ff == esc_pkg::ST_READY) use_ff <= use_ff + 1'b1;
               if (op_ff == esc_pkg::OP_DEMAND) pinned_ff[key_ff] <= 1'b1;
               else if (op_ff == esc_pkg::OP_USE) pinned_ff[key_ff] <= 1'b0;
            end else if (do_enq && take_ok) begin
               // An evicted slot's old job is replaced by the new one.
               valid_ff[tgt] <= 1'b1;
               pinned_ff[tgt] <= (op_ff == esc_pkg::OP_DEMAND);
               use_ff <= use_ff + 1'b1;
               ord_ff <= ord_ff + 1'b1;
               pending_ff[tgt] <= 1'b1;
            end else if (op_ff == esc_pkg::OP_UNPIN && key_hit_ff) begin
               pinned_ff[key_ff] <= 1'b0;
            end else if (op_ff == esc_pkg::OP_POP && job_hit_ff) begin
               pending_ff[job_ff] <= 1'b0;
            end else if (op_ff == esc_pkg::OP_COMPLETE && cpl_ok) begin
               use_ff <= use_ff + 1'b1;
            end
         end

         // Slot times stride.
         if (cmd.mul)
            prod_ff <= res_has_ff ? 56'(res_slot_ff) * 56'(stride_ff) : '0;

         // Result register.
         if (cmd.load_out) begin
            o_valid <= 1'b1;
            o_status <= res_status_ff;
            o_slot <= 6'(res_slot_ff);
            o_offset <= prod_ff;
            o_job_layer <= res_jl_ff;
            o_job_expert <= res_je_ff;
            o_evicted <= res_ev_ff;
         end else if (o_ready) begin
            o_valid <= 1'b0;
         end
      end
   end

`include "expert_slot_cache_controller_assert.svh"
   `ESC_ASSERT_NXT(a_out_valid, clock, reset, cmd.load_out, o_valid, "result not shown")
   `ESC_ASSERT_IMP(a_scan_range, clock, reset, cmd.scan, idx_ff <= limit, "scan overran")
   `ESC_ASSERT_NXT(a_no_overwrite, clock, reset, o_valid && !o_ready,
                   o_valid && $stable(o_status), "result lost")
endmodule

// ===== hdl/expert_slot_cache_controller.sv =====
// Top level of the expert slot cache controller.
// From the acceptance of a request to the next acceptance, the controller reads the first
// min(configured slots, 64) slots of the table one slot per cycle and checks each slot on
// the following cycle for the key, the first free slot, the least recently used evictable
// slot and the best pending job, then applies the operation, multiplies the slot by the
// configured byte stride and registers the result. A new request is accepted as soon as the
// previous result is in the output register; the following result waits in the controller,
// adding stall cycles, for as long as the receiver leaves that register full.
module expert_slot_cache_controller (
   input  logic      clock,
   input  logic      reset,
   esc_req_if.sink   req,
   esc_rsp_if.source rsp,
   esc_csr_if.sink   csr
);
   esc_pkg::ctrl_cmd_type  cmd;
   esc_pkg::ctrl_stat_type stat;
   logic req_fire;

   assign req_fire = req.valid && req.ready;
   assign csr.ready = 1'b1;

   esc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .stat(stat), .cmd(cmd),
      .req_ready(req.ready)
   );

   esc_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .i_op(req.op), .i_layer(req.layer), .i_expert(req.expert),
      .i_done_slot(req.done_slot), .i_load_ok(req.load_ok),
      .csr_we(csr.valid), .csr_idx(csr.index), .csr_wdata(csr.data),
      .o_valid(rsp.valid), .o_ready(rsp.ready), .o_status(rsp.status), .o_slot(rsp.slot),
      .o_offset(rsp.byte_offset), .o_job_layer(rsp.job_layer),
      .o_job_expert(rsp.job_expert), .o_evicted(rsp.evicted)
   );
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the expert slot cache controller with its own table predictor.
module tb_top;
   localparam logic [2:0] OP_UNKNOWN = 3'd7;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int PHASES = 8;
   localparam int CHUNK = 86;

   typedef struct {
      logic [2:0] op;
      logic [7:0] layer;
      logic [9:0] expert;
      logic [5:0] done_slot;
      logic       load_ok;
      bit         aim_loading;
   } request_type;

   typedef struct {
      logic [3:0]  status;
      logic [5:0]  slot;
      logic [55:0] byte_offset;
      logic [7:0]  job_layer;
      logic [9:0]  job_expert;
      logic        evicted;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   esc_req_if req ();
   esc_rsp_if rsp ();
   esc_csr_if csr ();

   expert_slot_cache_controller dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the slot table and registers.
   logic        m_policy;
   logic [6:0]  m_slots_cfg;
   logic [39:0] m_stride;
   logic        m_valid  [esc_pkg::SLOTS];
   logic [7:0]  m_layer  [esc_pkg::SLOTS];
   logic [9:0]  m_expert [esc_pkg::SLOTS];
   logic [1:0]  m_state  [esc_pkg::SLOTS];
   logic [47:0] m_last   [esc_pkg::SLOTS];
   logic        m_pinned [esc_pkg::SLOTS];
   logic        m_pend   [esc_pkg::SLOTS];
   logic        m_urgent [esc_pkg::SLOTS];
   logic [47:0] m_seq    [esc_pkg::SLOTS];
   logic [47:0] m_sort   [esc_pkg::SLOTS];
   logic [47:0] m_use_cnt;
   logic [47:0] m_order_cnt;

   request_type pending_requests[$];
   result_type  expected_results[$];
   request_type cur;
   int          errors = 0;
   int          cycles = 0;
   int          idle_mode = 0;
   bit          req_taken = 0;
   bit          csr_taken = 0;

   function automatic int active_slots();
      return (m_slots_cfg > esc_pkg::SLOTS) ? esc_pkg::SLOTS : int'(m_slots_cfg);
   endfunction

   function automatic logic [47:0] bump_use();
      m_use_cnt = m_use_cnt + 48'd1;
      return m_use_cnt;
   endfunction

   function automatic int lookup_key(logic [7:0] l, logic [9:0] e);
      for (int s = 0; s < active_slots(); s++)
         if (m_valid[s] && m_layer[s] == l && m_expert[s] == e) return s;
      return -1;
   endfunction

   // First free slot, else the least recently used slot that is unpinned and not loading.
   function automatic int claim_slot(ref logic ev);
      int victim;
      victim = -1;
      for (int s = 0; s < active_slots(); s++)
         if (!m_valid[s]) return s;
      for (int s = 0; s < active_slots(); s++) begin
         if (m_pinned[s] || m_state[s] == esc_pkg::ST_LOADING) continue;
         if (victim < 0 || m_last[s] < m_last[victim]) victim = s;
      end
      if (victim >= 0) begin
         ev = 1'b1;
         m_pend[victim] = 1'b0;
      end
      return victim;
   endfunction

   function automatic logic [3:0] queue_load(logic [7:0] l, logic [9:0] e, logic urg,
                                             ref int slot, ref logic ev);
      int s;
      s = lookup_key(l, e);
      if (s < 0) s = claim_slot(ev);
      if (s < 0) return esc_pkg::RS_NO_SLOT;
      m_valid[s] = 1'b1;
      m_layer[s] = l;
      m_expert[s] = e;
      m_state[s] = esc_pkg::ST_QUEUED;
      m_pinned[s] = 1'b0;
      m_last[s] = bump_use();
      m_order_cnt = m_order_cnt + 48'd1;
      m_pend[s] = 1'b1;
      m_urgent[s] = urg;
      m_seq[s] = m_order_cnt;
      m_sort[s] = m_order_cnt;
      slot = s;
      return esc_pkg::RS_ENQUEUED;
   endfunction

   function automatic bit job_ahead(int a, int b);
      if (m_urgent[a] != m_urgent[b]) return m_urgent[a];
      if (m_policy) begin
         if (m_layer[a] != m_layer[b]) return m_layer[a] < m_layer[b];
         if (m_sort[a] != m_sort[b]) return m_sort[a] < m_sort[b];
      end
      return m_seq[a] < m_seq[b];
   endfunction

   // Applies one request to the shadow table and returns the response it must produce.
   function automatic result_type cache_response(request_type r);
      result_type res;
      int slot, s, best;
      logic ev;
      res = '{esc_pkg::RS_NOT_RDY, 6'd0, 56'd0, 8'd0, 10'd0, 1'b0};
      slot = -1;
      ev = 1'b0;
      case (r.op)
         esc_pkg::OP_PREFETCH, esc_pkg::OP_DEMAND, esc_pkg::OP_USE: begin
            s = lookup_key(r.layer, r.expert);
            slot = s;
            if (s >= 0 && m_state[s] == esc_pkg::ST_READY) begin
               m_last[s] = bump_use();
               res.status = esc_pkg::RS_HIT;
            end else if (s >= 0 && m_state[s] == esc_pkg::ST_QUEUED) begin
               if (r.op == esc_pkg::OP_PREFETCH) res.status = esc_pkg::RS_LOADING;
               else begin
                  m_urgent[s] = 1'b1;
                  m_sort[s] = 48'd0;
                  res.status = esc_pkg::RS_PROMOTED;
               end
            end else if (s >= 0 && m_state[s] == esc_pkg::ST_LOADING) begin
               res.status = esc_pkg::RS_LOADING;
            end else begin
               slot = -1;
               res.status = queue_load(r.layer, r.expert, r.op != esc_pkg::OP_PREFETCH,
                                       slot, ev);
            end
            if (slot >= 0 && r.op == esc_pkg::OP_DEMAND) m_pinned[slot] = 1'b1;
            if (slot >= 0 && r.op == esc_pkg::OP_USE) m_pinned[slot] = 1'b0;
         end
         esc_pkg::OP_UNPIN: begin
            s = lookup_key(r.layer, r.expert);
            if (s >= 0) begin
               m_pinned[s] = 1'b0;
               slot = s;
               res.status = esc_pkg::RS_DONE;
            end
         end
         esc_pkg::OP_RELEASE: begin
            for (int i = 0; i < active_slots(); i++)
               if (m_valid[i] && m_layer[i] == r.layer) m_pinned[i] = 1'b0;
            res.status = esc_pkg::RS_DONE;
         end
         esc_pkg::OP_POP: begin
            best = -1;
            for (int i = 0; i < active_slots(); i++)
               if (m_pend[i] && (best < 0 || job_ahead(i, best))) best = i;
            if (best < 0) res.status = esc_pkg::RS_NO_JOB;
            else begin
               m_pend[best] = 1'b0;
               m_state[best] = esc_pkg::ST_LOADING;
               res.job_layer = m_layer[best];
               res.job_expert = m_expert[best];
               slot = best;
               res.status = esc_pkg::RS_JOB;
            end
         end
         esc_pkg::OP_COMPLETE: begin
            s = int'(r.done_slot);
            if (s < active_slots() && m_valid[s] && m_state[s] == esc_pkg::ST_LOADING) begin
               m_state[s] = r.load_ok ? esc_pkg::ST_READY : esc_pkg::ST_FAILED;
               m_last[s] = bump_use();
               slot = s;
               res.status = esc_pkg::RS_DONE;
            end
         end
         default: ;
      endcase
      if (slot >= 0) begin
         res.slot = slot[5:0];
         res.byte_offset = 56'(slot) * 56'(m_stride);
      end
      res.evicted = ev;
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [55:0] got, logic [55:0] want);
      $display("MISMATCH %s: got %0h expected %0h at cycle %0d", field, got, want, cycles);
      errors++;
   endtask

   // Acceptance of requests and configuration writes, and checking of responses.
   always @(posedge clock) begin
      result_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset) begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               esc_pkg::CSR_POLICY: m_policy = csr.data[0];
               esc_pkg::CSR_SLOTS:  m_slots_cfg = csr.data[6:0];
               esc_pkg::CSR_STRIDE: m_stride = csr.data;
               default: ;
            endcase
            csr_taken = 1;
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response", 56'(rsp.status), 56'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp.status !== want.status)
                  report_mismatch("status", 56'(rsp.status), 56'(want.status));
               if (rsp.slot !== want.slot)
                  report_mismatch("slot", 56'(rsp.slot), 56'(want.slot));
               if (rsp.byte_offset !== want.byte_offset)
                  report_mismatch("byte_offset", rsp.byte_offset, want.byte_offset);
               if (rsp.job_layer !== want.job_layer)
                  report_mismatch("job_layer", 56'(rsp.job_layer), 56'(want.job_layer));
               if (rsp.job_expert !== want.job_expert)
                  report_mismatch("job_expert", 56'(rsp.job_expert), 56'(want.job_expert));
               if (rsp.evicted !== want.evicted)
                  report_mismatch("evicted", 56'(rsp.evicted), 56'(want.evicted));
            end
         end
         if (req.valid && req.ready) begin
            expected_results = {expected_results, cache_response(cur)};
            req_taken = 1;
         end
      end
   end

   // Request driver and response stall, both changed on the falling edge.
   always @(negedge clock) begin
      int loading[$];
      bit send_idle, recv_stall;
      loading = {};
      send_idle = (idle_mode == 1 && $urandom_range(99) < 50) ||
                  (idle_mode == 3 && $urandom_range(99) < 9);
      recv_stall = (idle_mode == 2 && $urandom_range(99) < 50) ||
                   (idle_mode == 3 && $urandom_range(99) < 9);
      if (reset) begin
         req.valid <= 1'b0;
         req.op <= esc_pkg::OP_PREFETCH;
         req.layer <= '0;
         req.expert <= '0;
         req.done_slot <= '0;
         req.load_ok <= 1'b0;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= !recv_stall;
         if (req_taken || !req.valid) begin
            req_taken = 0;
            if (pending_requests.size() > 0 && !send_idle) begin
               cur = pending_requests.pop_front();
               // A completion aimed at a slot that is loading right now.
               if (cur.aim_loading) begin
                  for (int s = 0; s < active_slots(); s++)
                     if (m_valid[s] && m_state[s] == esc_pkg::ST_LOADING) loading = {loading, s};
                  if (loading.size() > 0)
                     cur.done_slot = 6'(loading[$urandom_range(loading.size() - 1)]);
               end
               req.op <= cur.op;
               req.layer <= cur.layer;
               req.expert <= cur.expert;
               req.done_slot <= cur.done_slot;
               req.load_ok <= cur.load_ok;
               req.valid <= 1'b1;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   task automatic add_request(logic [2:0] op, logic [7:0] l, logic [9:0] e,
                              logic [5:0] ds, logic ok, bit aim);
      request_type r;
      r = '{op, l, e, ds, ok, aim};
      pending_requests = {pending_requests, r};
   endtask

   task automatic add_random_request();
      int pick;
      logic [2:0] op;
      logic [7:0] l;
      logic [9:0] e;
      logic [9:0] experts[6];
      experts = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd512, 10'd1023};
      pick = $urandom_range(99);
      if (pick < 20) op = esc_pkg::OP_PREFETCH;
      else if (pick < 40) op = esc_pkg::OP_DEMAND;
      else if (pick < 55) op = esc_pkg::OP_USE;
      else if (pick < 62) op = esc_pkg::OP_UNPIN;
      else if (pick < 66) op = esc_pkg::OP_RELEASE;
      else if (pick < 82) op = esc_pkg::OP_POP;
      else if (pick < 98) op = esc_pkg::OP_COMPLETE;
      else op = OP_UNKNOWN;
      if ($urandom_range(99) < 85) begin
         l = ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom_range(4));
         e = experts[$urandom_range(5)];
      end else begin
         l = 8'($urandom);
         e = 10'($urandom);
      end
      add_request(op, l, e, 6'($urandom), $urandom_range(3) != 0,
                  $urandom_range(99) < 85);
   endtask

   task automatic write_register(logic [1:0] index, logic [39:0] value);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data <= value;
      csr_taken = 0;
      while (!csr_taken) @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || req.valid || expected_results.size() > 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      logic [6:0]  slot_settings[PHASES];
      logic [39:0] stride_settings[PHASES];
      slot_settings = '{7'd8, 7'd64, 7'd127, 7'd8, 7'd13, 7'd64, 7'd8, 7'd32};
      stride_settings = '{40'd1, 40'hFF_FFFF_FFFF, 40'($urandom), 40'd4096, 40'd1,
                          {8'($urandom), 32'($urandom)}, 40'hFF_FFFF_FFFF, 40'd3};
      m_policy = 1'b0;
      m_slots_cfg = 7'd64;
      m_stride = 40'd1;
      m_use_cnt = '0;
      m_order_cnt = '0;
      for (int s = 0; s < esc_pkg::SLOTS; s++) begin
         m_valid[s] = 1'b0;
         m_pinned[s] = 1'b0;
         m_pend[s] = 1'b0;
      end
      csr.valid = 1'b0;
      csr.index = esc_pkg::CSR_POLICY;
      csr.data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed pass on eight slots: fill, promote, pop, fail, evict, then a hit or a retry.
      write_register(esc_pkg::CSR_SLOTS, 40'd8);
      write_register(esc_pkg::CSR_STRIDE, 40'hFF_FFFF_FFFF);
      for (int i = 0; i < 8; i++)
         add_request(i[0] ? esc_pkg::OP_DEMAND : esc_pkg::OP_PREFETCH, 8'(i), 10'(i * 100),
                     6'd0, 1'b1, 0);
      add_request(esc_pkg::OP_PREFETCH, 8'd0, 10'd0, 6'd0, 1'b1, 0);
      add_request(esc_pkg::OP_USE, 8'd2, 10'd200, 6'd0, 1'b1, 0);
      add_request(esc_pkg::OP_POP, 8'd0, 10'd0, 6'd0, 1'b0, 0);
      add_request(esc_pkg::OP_POP, 8'd0, 10'd0, 6'd0, 1'b0, 0);
      add_request(esc_pkg::OP_COMPLETE, 8'd0, 10'd0, 6'd63, 1'b1, 0);
      add_request(esc_pkg::OP_COMPLETE, 8'd0, 10'd0, 6'd0, 1'b0, 1);
      add_request(esc_pkg::OP_COMPLETE, 8'd0, 10'd0, 6'd0, 1'b1, 1);
      add_request(esc_pkg::OP_DEMAND, 8'd255, 10'd1023, 6'd0, 1'b1, 0);
      add_request(esc_pkg::OP_UNPIN, 8'd1, 10'd100, 6'd0, 1'b1, 0);
      add_request(esc_pkg::OP_UNPIN, 8'd200, 10'd5, 6'd0, 1'b1, 0);
      add_request(esc_pkg::OP_RELEASE, 8'd3, 10'd0, 6'd0, 1'b1, 0);
      add_request(OP_UNKNOWN, 8'hFF, 10'h3FF, 6'h3F, 1'b1, 0);
      for (int i = 0; i < 9; i++) add_request(esc_pkg::OP_POP, 8'd0, 10'd0, 6'd0, 1'b0, 0);
      add_request(esc_pkg::OP_PREFETCH, 8'd2, 10'd200, 6'd0, 1'b1, 0);
      drain();

      // Random phases, each with its own register setting and idling pattern.
      for (int p = 0; p < PHASES; p++) begin
         write_register(esc_pkg::CSR_POLICY, 40'(p % 2));
         write_register(esc_pkg::CSR_SLOTS, 40'(slot_settings[p]));
         write_register(esc_pkg::CSR_STRIDE, stride_settings[p]);
         idle_mode = p % 4;
         for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < CHUNK; i++) add_random_request();
            // Hold further requests until every response of this chunk is back.
            drain();
         end
      end
      idle_mode = 0;
      repeat (80) @(negedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== expert_slot_cache_controller.f =====
+incdir+hdl
hdl/esc_pkg.sv
hdl/esc_if.sv
hdl/esc_ctrl.sv
hdl/esc_dp.sv
hdl/expert_slot_cache_controller.sv
tb/tb_top.sv
